>>> rtl/biq_pkg.sv
// ----------------------------------------------------------------------------
// biq_pkg
// shared codes and the command/status types between controller and datapath
// ----------------------------------------------------------------------------
package biq_pkg;

	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] REG_FORM = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_B0   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_B1   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_B2   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_A1   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_A2   = 3'd5;

	localparam logic FORM_DF1 = 1'b0;
	localparam logic FORM_DF2 = 1'b1;

	typedef logic [2:0] coef_sel_t;
	localparam coef_sel_t COEF_B0 = 3'd0;
	localparam coef_sel_t COEF_B1 = 3'd1;
	localparam coef_sel_t COEF_B2 = 3'd2;
	localparam coef_sel_t COEF_A1 = 3'd3;
	localparam coef_sel_t COEF_A2 = 3'd4;

	typedef logic [2:0] dat_sel_t;
	localparam dat_sel_t DAT_X   = 3'd0;
	localparam dat_sel_t DAT_PI1 = 3'd1;
	localparam dat_sel_t DAT_PI2 = 3'd2;
	localparam dat_sel_t DAT_PO1 = 3'd3;
	localparam dat_sel_t DAT_PO2 = 3'd4;
	localparam dat_sel_t DAT_Y   = 3'd5;

	typedef logic [1:0] acc_base_t;
	localparam acc_base_t BASE_ACC  = 2'd0;
	localparam acc_base_t BASE_ZERO = 2'd1;
	localparam acc_base_t BASE_PS1  = 2'd2;
	localparam acc_base_t BASE_PS2  = 2'd3;

	typedef logic [2:0] step_t;
	localparam step_t LAST_STEP_DF1 = 3'd6;
	localparam step_t LAST_STEP_DF2 = 3'd7;

	typedef struct packed {
		logic      load_x;
		logic      mul_en;
		coef_sel_t coef_sel;
		dat_sel_t  dat_sel;
		logic      acc_en;
		acc_base_t acc_base;
		logic      acc_sub;
		logic      y_en;
		logic      shift_en;
		logic      wr_ps1;
		logic      wr_ps2;
		logic      out_load;
	} cmd_t;

	typedef struct packed {
		logic form;
	} status_t;

endpackage

>>> rtl/biq_dpath.sv
// ----------------------------------------------------------------------------
// biq_dpath
// config registers, filter state, shared multiplier, accumulator, round/sat
// ----------------------------------------------------------------------------
module biq_dpath #(
	parameter int SAMPLE_WIDTH = 16,
	parameter int COEF_WIDTH   = 20
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [biq_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [COEF_WIDTH-1:0]          cfg_data,
	input  logic signed [SAMPLE_WIDTH-1:0] sample_in,
	output logic signed [SAMPLE_WIDTH-1:0] sample_out,
	input  biq_pkg::cmd_t                  cmd,
	output biq_pkg::status_t               status
);

	localparam int SW     = SAMPLE_WIDTH;
	localparam int CW     = COEF_WIDTH;
	localparam int PROD_W = SW + CW;
	localparam int AW     = (SW + CW + 5 > 64) ? 64 : SW + CW + 5;
	localparam int PW     = (SW + CW + 4 > 64) ? 64 : SW + CW + 4;
	localparam int RSH    = CW - 4;

	localparam logic [AW-1:0]        RND   = {{(AW-1){1'b0}}, 1'b1} << (RSH - 1);
	localparam logic signed [SW-1:0] Y_MAX = {1'b0, {(SW-1){1'b1}}};
	localparam logic signed [SW-1:0] Y_MIN = {1'b1, {(SW-1){1'b0}}};

	logic                     form_q;
	logic signed [CW-1:0]     b0_q, b1_q, b2_q, a1_q, a2_q;
	logic signed [SW-1:0]     pi1_q, pi2_q, po1_q, po2_q;
	logic signed [PW-1:0]     ps1_q, ps2_q;
	logic signed [SW-1:0]     x_q, y_q, out_q;
	logic signed [PROD_W-1:0] prod_s1;
	logic signed [AW-1:0]     acc_q;

	logic signed [CW-1:0]     coef_m;
	logic signed [SW-1:0]     dat_m;
	logic signed [AW-1:0]     base_m, prod_ext, acc_nxt;
	logic signed [AW-1:0]     rnd, q;
	logic                     sat_hi, sat_lo;
	logic signed [SW-1:0]     y_rs;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			form_q <= biq_pkg::FORM_DF1;
			b0_q   <= '0;
			b1_q   <= '0;
			b2_q   <= '0;
			a1_q   <= '0;
			a2_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				biq_pkg::REG_FORM: form_q <= cfg_data[0];
				biq_pkg::REG_B0:   b0_q   <= cfg_data;
				biq_pkg::REG_B1:   b1_q   <= cfg_data;
				biq_pkg::REG_B2:   b2_q   <= cfg_data;
				biq_pkg::REG_A1:   a1_q   <= cfg_data;
				biq_pkg::REG_A2:   a2_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	assign status.form = form_q;

	// operand select
	always_comb begin
		case (cmd.coef_sel)
			biq_pkg::COEF_B0: coef_m = b0_q;
			biq_pkg::COEF_B1: coef_m = b1_q;
			biq_pkg::COEF_B2: coef_m = b2_q;
			biq_pkg::COEF_A1: coef_m = a1_q;
			biq_pkg::COEF_A2: coef_m = a2_q;
			default:          coef_m = '0;
		endcase
		case (cmd.dat_sel)
			biq_pkg::DAT_X:   dat_m = x_q;
			biq_pkg::DAT_PI1: dat_m = pi1_q;
			biq_pkg::DAT_PI2: dat_m = pi2_q;
			biq_pkg::DAT_PO1: dat_m = po1_q;
			biq_pkg::DAT_PO2: dat_m = po2_q;
			biq_pkg::DAT_Y:   dat_m = y_q;
			default:          dat_m = '0;
		endcase
		case (cmd.acc_base)
			biq_pkg::BASE_ACC:  base_m = acc_q;
			biq_pkg::BASE_ZERO: base_m = '0;
			biq_pkg::BASE_PS1:  base_m = AW'(ps1_q);
			biq_pkg::BASE_PS2:  base_m = AW'(ps2_q);
			default:            base_m = '0;
		endcase
	end

	assign prod_ext = AW'(prod_s1);
	assign acc_nxt  = cmd.acc_sub ? base_m - prod_ext : base_m + prod_ext;

	// round half up, then saturate
	assign rnd    = acc_q + $signed(RND);
	assign q      = rnd >>> RSH;
	assign sat_hi = ~q[AW-1] & (|q[AW-2:SW-1]);
	assign sat_lo = q[AW-1] & ~(&q[AW-2:SW-1]);
	assign y_rs   = sat_hi ? Y_MAX : (sat_lo ? Y_MIN : q[SW-1:0]);

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load_x)
			x_q <= sample_in;
		if (cmd.mul_en)
			prod_s1 <= coef_m * dat_m;
		if (cmd.acc_en)
			acc_q <= acc_nxt;
		if (cmd.y_en)
			y_q <= y_rs;
		if (cmd.out_load)
			out_q <= y_q;
	end

	// filter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pi1_q <= '0;
			pi2_q <= '0;
			po1_q <= '0;
			po2_q <= '0;
			ps1_q <= '0;
			ps2_q <= '0;
		end else begin
			if (cmd.shift_en) begin
				pi2_q <= pi1_q;
				pi1_q <= x_q;
				po2_q <= po1_q;
				po1_q <= y_rs;
			end
			if (cmd.wr_ps1)
				ps1_q <= PW'(acc_q);
			if (cmd.wr_ps2)
				ps2_q <= PW'(acc_q);
		end
	end

	assign sample_out = out_q;

endmodule

>>> rtl/biq_ctrl.sv
// ----------------------------------------------------------------------------
// biq_ctrl
// sequencer: issues at most one multiply and one accumulate per step, owns handshakes
// ----------------------------------------------------------------------------
module biq_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	input  biq_pkg::status_t status,
	output biq_pkg::cmd_t    cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_FIN  = 2'd2;

	logic [1:0]      state_q;
	biq_pkg::step_t  step_q;
	logic            out_valid_q;
	logic            last;
	logic            accept;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign accept    = in_valid & in_ready;
	assign last      = (status.form == biq_pkg::FORM_DF2) ?
		(step_q == biq_pkg::LAST_STEP_DF2) : (step_q == biq_pkg::LAST_STEP_DF1);

	always_comb begin
		cmd          = '0;
		cmd.load_x   = accept;
		cmd.out_load = (state_q == ST_FIN) & (~out_valid_q | out_ready);
		if (state_q == ST_RUN) begin
			if (status.form == biq_pkg::FORM_DF1) begin
				case (step_q)
					3'd0: begin
						cmd.mul_en = 1'b1; cmd.coef_sel = biq_pkg::COEF_B0;
						cmd.dat_sel = biq_pkg::DAT_X;
					end
					3'd1: begin
						cmd.mul_en = 1'b1; cmd.coef_sel = biq_pkg::COEF_B1;
						cmd.dat_sel = biq_pkg::DAT_PI1;
						cmd.acc_en = 1'b1; cmd.acc_base = biq_pkg::BASE_ZERO;
					end
					3'd2: begin
						cmd.mul_en = 1'b1; cmd.coef_sel = biq_pkg::COEF_B2;
						cmd.dat_sel = biq_pkg::DAT_PI2;
						cmd.acc_en = 1'b1; cmd.acc_base = biq_pkg::BASE_ACC;
					end
					3'd3: begin
						cmd.mul_en = 1'b1; cmd.coef_sel = biq_pkg::COEF_A1;
						cmd.dat_sel = biq_pkg::DAT_PO1;
						cmd.acc_en = 1'b1; cmd.acc_base = biq_pkg::BASE_ACC;
					end
					3'd4: begin
						cmd.mul_en = 1'b1; cmd.coef_sel = biq_pkg::COEF_A2;
						cmd.dat_sel = biq_pkg::DAT_PO2;
						cmd.acc_en = 1'b1; cmd.acc_base = biq_pkg::BASE_ACC;
						cmd.acc_sub = 1'b1;
					end
					3'd5: begin
						cmd.acc_en = 1'b1; cmd.acc_base = biq_pkg::BASE_ACC;
						cmd.acc_sub = 1'b1;
					end
					3'd6: begin
						cmd.y_en = 1'b1; cmd.shift_en = 1'b1;
					end
					default: ;
				endcase
			end else begin
				case (step_q)
					3'd0: begin
						cmd.mul_en = 1'b1; cmd.coef_sel = biq_pkg::COEF_B0;
						cmd.dat_sel = biq_pkg::DAT_X;
					end
					3'd1: begin
						cmd.acc_en = 1'b1; cmd.acc_base = biq_pkg::BASE_PS1;
					end
					3'd2: begin
						cmd.y_en = 1'b1;
						cmd.mul_en = 1'b1; cmd.coef_sel = biq_pkg::COEF_B1;
						cmd.dat_sel = biq_pkg::DAT_X;
					end
					3'd3: begin
						cmd.mul_en = 1'b1; cmd.coef_sel = biq_pkg::COEF_A1;
						cmd.dat_sel = biq_pkg::DAT_Y;
						cmd.acc_en = 1'b1; cmd.acc_base = biq_pkg::BASE_PS2;
					end
					3'd4: begin
						cmd.mul_en = 1'b1; cmd.coef_sel = biq_pkg::COEF_B2;
						cmd.dat_sel = biq_pkg::DAT_X;
						cmd.acc_en = 1'b1; cmd.acc_base = biq_pkg::BASE_ACC;
						cmd.acc_sub = 1'b1;
					end
					3'd5: begin
						cmd.wr_ps1 = 1'b1;
						cmd.mul_en = 1'b1; cmd.coef_sel = biq_pkg::COEF_A2;
						cmd.dat_sel = biq_pkg::DAT_Y;
						cmd.acc_en = 1'b1; cmd.acc_base = biq_pkg::BASE_ZERO;
					end
					3'd6: begin
						cmd.acc_en = 1'b1; cmd.acc_base = biq_pkg::BASE_ACC;
						cmd.acc_sub = 1'b1;
					end
					3'd7: begin
						cmd.wr_ps2 = 1'b1;
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_RUN;
						step_q  <= '0;
					end
				end
				ST_RUN: begin
					if (last)
						state_q <= ST_FIN;
					else
						step_q <= step_q + 3'd1;
				end
				ST_FIN: begin
					if (cmd.out_load)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_RUN) && (step_q == 3'd0))
		else $error("accepted item did not start at step zero");

	a_step_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) && !last |=> (state_q == ST_RUN) &&
		(step_q == $past(step_q) + 3'd1))
		else $error("sequencer skipped or stalled a step");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !out_valid_q || out_ready)
		else $error("pending result overwritten");

	a_valid_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_FIN))
		else $error("result raised outside finish state");

	a_df1_short: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) && (status.form == biq_pkg::FORM_DF1) |->
		(step_q != biq_pkg::LAST_STEP_DF2))
		else $error("direct form I ran past its last step");

endmodule

>>> rtl/biquad_iir_filter.sv
// ----------------------------------------------------------------------------
// biquad_iir_filter
// second-order IIR section, direct form I or transposed direct form II
// ----------------------------------------------------------------------------
// Samples enter on sample_in with in_valid/in_ready and leave on sample_out
// with out_valid/out_ready; every accepted item yields exactly one result.
// Coefficients and the form select are written through cfg_we/cfg_index/
// cfg_data only while no item is in flight, which the user must ensure and
// the block does not enforce; indexes above five are ignored. One shared
// multiplier forms the five products in turn, each registered before it is
// added into a full-width accumulator, then the sum is rounded and
// saturated to SAMPLE_WIDTH bits. The sequencer steps an accepted item
// through the multiply/accumulate sequence of the selected form, then a
// finish state loads the result into the output register and raises
// out_valid; only one item is in the sequence at a time.
// A finished result sits in an output register; the next item is accepted as
// soon as the previous one reaches it. If the receiver stalls, the following
// item is computed and then held until the output register is taken.
// Reset clears coefficients, form select, delay lines and partial sums to zero.
// ----------------------------------------------------------------------------
module biquad_iir_filter #(
	parameter int SAMPLE_WIDTH = 16,
	parameter int COEF_WIDTH   = 20
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [biq_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [COEF_WIDTH-1:0]          cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic signed [SAMPLE_WIDTH-1:0] sample_in,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic signed [SAMPLE_WIDTH-1:0] sample_out
);

	biq_pkg::cmd_t    cmd;
	biq_pkg::status_t status;

	biq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	biq_dpath #(
		.SAMPLE_WIDTH (SAMPLE_WIDTH),
		.COEF_WIDTH   (COEF_WIDTH)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.sample_in  (sample_in),
		.sample_out (sample_out),
		.cmd        (cmd),
		.status     (status)
	);

endmodule

>>> sim/biquad_checker.sv
// ----------------------------------------------------------------------------
// biquad_checker
// Watches the configuration port and both sample channels of the biquad.
// Keeps its own copy of the coefficients, the form select and the state of
// both filter structures, predicts each output sample from every accepted
// input item and compares it with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module biquad_checker #(
	parameter int SAMPLE_WIDTH = 16,
	parameter int COEF_WIDTH   = 20
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [biq_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [COEF_WIDTH-1:0]          cfg_data,
	input  logic                           in_valid,
	input  logic                           in_ready,
	input  logic signed [SAMPLE_WIDTH-1:0] sample_in,
	input  logic                           out_valid,
	input  logic                           out_ready,
	input  logic signed [SAMPLE_WIDTH-1:0] sample_out,
	input  logic                           end_of_test,
	output int                             fail_count,
	output int                             open_items,
	output int                             checked
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ROUND_SHIFT = COEF_WIDTH - 4;
	localparam int PSUM_WIDTH  = SAMPLE_WIDTH + COEF_WIDTH + 4;
	localparam int MAX_PRINTS  = 30;
	localparam longint SAT_HI  = (longint'(1) <<< (SAMPLE_WIDTH - 1)) - 1;
	localparam longint SAT_LO  = -SAT_HI - 1;

	typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
	typedef logic signed [COEF_WIDTH-1:0]   coef_t;
	typedef logic signed [PSUM_WIDTH-1:0]   psum_t;

	logic    form;
	coef_t   b0, b1, b2, a1, a2;
	sample_t x_d1, x_d2, y_d1, y_d2;
	psum_t   psum_1, psum_2;
	sample_t expected_q[$];
	sample_t want;
	logic    end_seen;

	function automatic longint prod(coef_t c, sample_t s);
		return longint'(c) * longint'(s);
	endfunction

	function automatic sample_t round_saturate(longint acc);
		longint q;
		q = (acc + (longint'(1) <<< (ROUND_SHIFT - 1))) >>> ROUND_SHIFT;
		if (q > SAT_HI)
			q = SAT_HI;
		else if (q < SAT_LO)
			q = SAT_LO;
		return sample_t'(q);
	endfunction

	// only the selected structure moves, the other keeps its state
	function automatic sample_t filter_sample(sample_t x);
		longint  acc;
		sample_t y;
		if (form == biq_pkg::FORM_DF1) begin
			acc = prod(b0, x) + prod(b1, x_d1) + prod(b2, x_d2)
				- prod(a1, y_d1) - prod(a2, y_d2);
			y = round_saturate(acc);
			x_d2 = x_d1;
			x_d1 = x;
			y_d2 = y_d1;
			y_d1 = y;
		end else begin
			acc = prod(b0, x) + longint'(psum_1);
			y = round_saturate(acc);
			psum_1 = psum_t'(longint'(psum_2) + prod(b1, x) - prod(a1, y));
			psum_2 = psum_t'(prod(b2, x) - prod(a2, y));
		end
		return y;
	endfunction

	task automatic report_mismatch(input string what);
		fail_count++;
		if (fail_count <= MAX_PRINTS)
			$display("%0t ns: %s", $time, what);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			form = biq_pkg::FORM_DF1;
			b0 = '0;
			b1 = '0;
			b2 = '0;
			a1 = '0;
			a2 = '0;
			x_d1 = '0;
			x_d2 = '0;
			y_d1 = '0;
			y_d2 = '0;
			psum_1 = '0;
			psum_2 = '0;
			expected_q.delete();
			fail_count = 0;
			checked = 0;
			end_seen = 1'b0;
			open_items <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					biq_pkg::REG_FORM: form = cfg_data[0];
					biq_pkg::REG_B0:   b0 = coef_t'(cfg_data);
					biq_pkg::REG_B1:   b1 = coef_t'(cfg_data);
					biq_pkg::REG_B2:   b2 = coef_t'(cfg_data);
					biq_pkg::REG_A1:   a1 = coef_t'(cfg_data);
					biq_pkg::REG_A2:   a2 = coef_t'(cfg_data);
					default:  ;
				endcase
			end
			if (out_valid && out_ready) begin
				checked++;
				if (expected_q.size() == 0) begin
					report_mismatch($sformatf("result %0d (%0d) arrived with no item waiting",
						checked, sample_out));
				end else begin
					want = expected_q.pop_front();
					if (sample_out !== want)
						report_mismatch($sformatf("sample_out of result %0d is %0d, expected %0d",
							checked, sample_out, want));
				end
			end
			if (in_valid && in_ready)
				expected_q.push_back(filter_sample(sample_in));
			open_items <= open_items + int'(in_valid && in_ready) - int'(out_valid && out_ready);
			if (end_of_test && !end_seen) begin
				end_seen = 1'b1;
				if (expected_q.size() != 0)
					report_mismatch($sformatf("%0d items never got a result",
						expected_q.size()));
			end
		end
	end

endmodule

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives the biquad section with directed and random audio samples under many
// coefficient sets in both filter forms, with bursty input and a stalling
// output, and lets biquad_checker predict and compare every result.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SAMPLE_WIDTH  = 16;
	localparam int COEF_WIDTH    = 20;
	localparam int RESET_CYCLES  = 6;
	localparam int DIRECTED      = 22;
	localparam int RANDOM_ITEMS  = 1830;
	localparam int DRAIN_CYCLES  = 12;
	localparam int LIMIT_CYCLES  = 400000;
	localparam int COEF_MAX      = 524287;
	localparam int COEF_MIN      = -524288;
	localparam int UNITY         = 65536;

	localparam logic [biq_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [biq_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

	typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
	typedef logic signed [COEF_WIDTH-1:0]   coef_t;

	typedef struct packed {
		logic  form;
		coef_t b0;
		coef_t b1;
		coef_t b2;
		coef_t a1;
		coef_t a2;
	} filter_cfg_t;

	typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_PATTERN} rx_mode_t;

	logic                           clk = 1'b0;
	logic                           arst_n;
	logic                           cfg_we;
	logic [biq_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [COEF_WIDTH-1:0]          cfg_data;
	logic                           in_valid;
	logic                           in_ready;
	sample_t                        sample_in;
	logic                           out_valid;
	logic                           out_ready = 1'b0;
	sample_t                        sample_out;
	logic                           end_of_test;
	int                             fail_count;
	int                             open_items;
	int                             checked;

	int       cycles = 0;
	int       items_sent = 0;
	int       settings_used = 0;
	int       form_switches = 0;
	int       burst_left = 0;
	logic     cur_form = biq_pkg::FORM_DF1;
	rx_mode_t rx_mode = RX_OPEN;
	int       rx_left = 0;
	logic [7:0] rx_pattern = 8'hff;

	sample_t directed_samples[DIRECTED] = '{
		32767, -32768,
		32767, -32768, 0, 1, -1, 32767,
		32767, -32768, 12345, -1,
		-32768, 32767, 100,
		-1, 32767, -32768,
		32767, 0, -20000, 5000
	};

	biquad_iir_filter #(
		.SAMPLE_WIDTH(SAMPLE_WIDTH),
		.COEF_WIDTH  (COEF_WIDTH)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.sample_in (sample_in),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sample_out(sample_out)
	);

	biquad_checker #(
		.SAMPLE_WIDTH(SAMPLE_WIDTH),
		.COEF_WIDTH  (COEF_WIDTH)
	) u_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.sample_in  (sample_in),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.sample_out (sample_out),
		.end_of_test(end_of_test),
		.fail_count (fail_count),
		.open_items (open_items),
		.checked    (checked)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT_CYCLES) begin
			$display("timeout after %0d cycles, %0d items still open", cycles, open_items);
			$display("Some tests failed");
			$finish;
		end
	end

	// receiver stalls follow a mode that is picked anew whenever its countdown runs out
	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_mode <= rx_mode_t'($urandom_range(3));
			rx_left <= $urandom_range(20, 300);
			rx_pattern <= 8'($urandom) | 8'h01;
		end else begin
			rx_left <= rx_left - 1;
		end
		case (rx_mode)
			RX_OPEN:   out_ready <= 1'b1;
			RX_COIN:   out_ready <= 1'($urandom_range(1));
			RX_SPARSE: out_ready <= ($urandom_range(3) == 0);
			default:   out_ready <= rx_pattern[rx_left % 8];
		endcase
	end

	function automatic sample_t pick_sample();
		case ($urandom_range(9))
			0: begin
				case ($urandom_range(4))
					0:       return sample_t'(32767);
					1:       return sample_t'(-32768);
					2:       return sample_t'(0);
					3:       return sample_t'(1);
					default: return sample_t'(-1);
				endcase
			end
			1, 2:    return sample_t'(int'($urandom_range(0, 1024)) - 512);
			default: return sample_t'($urandom);
		endcase
	endfunction

	// span zero means the whole coefficient range
	function automatic coef_t pick_coef(int span);
		if (span == 0)
			return coef_t'($urandom);
		return coef_t'(int'($urandom_range(0, 2 * span)) - span);
	endfunction

	function automatic coef_t pick_extreme_coef();
		case ($urandom_range(5))
			0:       return coef_t'(COEF_MAX);
			1:       return coef_t'(COEF_MIN);
			2:       return coef_t'(0);
			3:       return coef_t'(-1);
			4:       return coef_t'(UNITY);
			default: return coef_t'(-UNITY);
		endcase
	endfunction

	function automatic filter_cfg_t pick_settings();
		filter_cfg_t c;
		c.form = 1'($urandom_range(1));
		case ($urandom_range(4))
			0: begin
				c.b0 = pick_coef(0);
				c.b1 = pick_coef(0);
				c.b2 = pick_coef(0);
				c.a1 = pick_coef(0);
				c.a2 = pick_coef(0);
			end
			1: begin
				c.b0 = pick_extreme_coef();
				c.b1 = pick_extreme_coef();
				c.b2 = pick_extreme_coef();
				c.a1 = pick_extreme_coef();
				c.a2 = pick_extreme_coef();
			end
			2, 3: begin
				// roughly audio-like sections
				c.b0 = pick_coef(40000);
				c.b1 = pick_coef(40000);
				c.b2 = pick_coef(40000);
				c.a1 = pick_coef(131072);
				c.a2 = pick_coef(60000);
			end
			default: begin
				// plain gain
				c.b0 = pick_coef(UNITY);
				c.b1 = '0;
				c.b2 = '0;
				c.a1 = '0;
				c.a2 = '0;
			end
		endcase
		return c;
	endfunction

	task automatic send_sample(sample_t x);
		in_valid <= 1'b1;
		sample_in <= x;
		do @(posedge clk); while (!in_ready);
		items_sent++;
	endtask

	task automatic pause_sender(int n);
		in_valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (open_items != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_form(logic f, logic [COEF_WIDTH-2:0] upper);
		cfg_we <= 1'b1;
		cfg_index <= biq_pkg::REG_FORM;
		cfg_data <= {upper, f};
		@(posedge clk);
		cfg_we <= 1'b0;
		if (f != cur_form)
			form_switches++;
		cur_form = f;
	endtask

	task automatic apply_settings(filter_cfg_t c, bit with_spare);
		cfg_we <= 1'b1;
		cfg_index <= biq_pkg::REG_FORM;
		cfg_data <= {(COEF_WIDTH - 1)'($urandom), c.form};
		@(posedge clk);
		cfg_index <= biq_pkg::REG_B0;
		cfg_data <= c.b0;
		@(posedge clk);
		cfg_index <= biq_pkg::REG_B1;
		cfg_data <= c.b1;
		@(posedge clk);
		cfg_index <= biq_pkg::REG_B2;
		cfg_data <= c.b2;
		@(posedge clk);
		cfg_index <= biq_pkg::REG_A1;
		cfg_data <= c.a1;
		@(posedge clk);
		cfg_index <= biq_pkg::REG_A2;
		cfg_data <= c.a2;
		@(posedge clk);
		if (with_spare) begin
			// writes to unmapped indexes must change nothing
			cfg_index <= REG_SPARE_LO;
			cfg_data <= COEF_WIDTH'($urandom);
			@(posedge clk);
			cfg_index <= REG_SPARE_HI;
			cfg_data <= '1;
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		if (c.form != cur_form)
			form_switches++;
		cur_form = c.form;
		settings_used++;
	endtask

	task automatic stream_samples(int n, bit mid_drain);
		int gap;
		for (int i = 0; i < n; i++) begin
			if (mid_drain && i == n / 2)
				wait_drained();
			send_sample(pick_sample());
			if (burst_left > 0) begin
				burst_left--;
			end else begin
				burst_left = $urandom_range(1, 60);
				gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 12);
				if (gap > 0)
					pause_sender(gap);
			end
		end
	endtask

	initial begin
		int n;
		cfg_we <= 1'b0;
		cfg_index <= biq_pkg::REG_FORM;
		cfg_data <= '0;
		in_valid <= 1'b0;
		sample_in <= '0;
		end_of_test <= 1'b0;
		arst_n <= 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: zero coefficients out of reset, saturating extremes,
		// form switches that must keep each structure's own state
		for (int i = 0; i < DIRECTED; i++) begin
			case (i)
				2: begin
					wait_drained();
					apply_settings('{biq_pkg::FORM_DF1, coef_t'(COEF_MAX), coef_t'(COEF_MIN),
						coef_t'(UNITY), coef_t'(COEF_MIN), coef_t'(COEF_MAX)}, 1'b1);
				end
				8: begin
					wait_drained();
					set_form(biq_pkg::FORM_DF2, '1);
				end
				12: begin
					wait_drained();
					set_form(biq_pkg::FORM_DF1, '1);
				end
				15: begin
					wait_drained();
					set_form(biq_pkg::FORM_DF2, '0);
				end
				18: begin
					wait_drained();
					apply_settings('{biq_pkg::FORM_DF2, 20'sd4424, 20'sd8848, 20'sd4424,
						-20'sd74908, 20'sd27054}, 1'b0);
				end
				default: ;
			endcase
			send_sample(directed_samples[i]);
		end
		wait_drained();

		while (items_sent < DIRECTED + RANDOM_ITEMS) begin
			n = $urandom_range(20, 160);
			if (n > DIRECTED + RANDOM_ITEMS - items_sent)
				n = DIRECTED + RANDOM_ITEMS - items_sent;
			if ($urandom_range(3) == 0)
				set_form(~cur_form, (COEF_WIDTH - 1)'($urandom));
			else
				apply_settings(pick_settings(), $urandom_range(3) == 0);
			stream_samples(n, $urandom_range(4) == 0);
			wait_drained();
		end

		end_of_test <= 1'b1;
		repeat (2) @(posedge clk);
		$display("ran %0d samples through %0d coefficient sets with %0d form changes",
			items_sent, settings_used, form_switches);
		$display("%0d results compared, %0d mismatches", checked, fail_count);
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
